@@ hdl/nearest_neighbour_classifier_macros.svh @@
// Assertion macros used by the checker of the classifier.
// No dependencies; include once per file that asserts.
`ifndef NEAREST_NEIGHBOUR_CLASSIFIER_MACROS_SVH
`define NEAREST_NEIGHBOUR_CLASSIFIER_MACROS_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define NNC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication from one cycle to the next.
`define NNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/nnc_pkg.sv @@
// Shared types, widths and codes of the nearest-neighbour classifier.
// No dependencies; imported by every module of the block.
package nnc_pkg;

  // Field widths.
  localparam int FEAT_W   = 16;
  localparam int NUM_FEAT = 4;
  localparam int LABEL_W  = 8;
  localparam int DIST_W   = 34;
  localparam int COUNT_W  = 6;
  localparam int INDEX_W  = 5;
  localparam int SQ_W     = 2 * FEAT_W;

  // Table depth default.
  localparam int DEF_TABLE_DEPTH = 32;

  // Configuration registers and their reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'b1;
  localparam logic [COUNT_W-1:0] RESET_SAMPLE_COUNT   = 6'd25;
  localparam logic [DIST_W-1:0]  RESET_DISTANCE_LIMIT = 34'h0_FFFF_FFFF;

  // Input command codes (carried in tuser).
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Input tdata layout, lowest bit first.
  localparam int IN_INDEX_LSB = 0;
  localparam int IN_LABEL_LSB = IN_INDEX_LSB + INDEX_W;
  localparam int IN_FEAT_LSB  = IN_LABEL_LSB + LABEL_W;
  localparam int IN_USED_W    = IN_FEAT_LSB + NUM_FEAT * FEAT_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_LABEL_LSB = 0;
  localparam int OUT_DIST_LSB  = OUT_LABEL_LSB + LABEL_W;
  localparam int OUT_FOUND_LSB = OUT_DIST_LSB + DIST_W;
  localparam int OUT_USED_W    = OUT_FOUND_LSB + 1;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // Four features packed, feature a in the lowest bits.
  typedef logic [NUM_FEAT-1:0][FEAT_W-1:0] feat_vec_t;

  // Control tag that travels with each slot of the distance pipeline.
  typedef struct packed {
    logic active;  // slot carries work of the current query
    logic entry;   // slot holds a table entry to compare
    logic last;    // final slot of the query
  } nnc_tag_t;

  // Absolute difference of two unsigned features.
  function automatic logic [FEAT_W-1:0] abs_diff(input logic [FEAT_W-1:0] x,
                                                 input logic [FEAT_W-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

endpackage

@@ hdl/nnc_store.sv @@
// Sample table of the classifier: one write port, one registered read port.
// Depends on nnc_pkg for the label and feature types.
module nnc_store import nnc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [LABEL_W-1:0] wr_label_i,
  input  feat_vec_t          wr_feat_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [LABEL_W-1:0] rd_label_o,
  output feat_vec_t          rd_feat_o
);

  localparam int WORD_W = LABEL_W + NUM_FEAT * FEAT_W;

  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_label_i, wr_feat_i};
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_feat_o  = rd_word_q[NUM_FEAT*FEAT_W-1:0];
  assign rd_label_o = rd_word_q[WORD_W-1:NUM_FEAT*FEAT_W];

endmodule

@@ hdl/nnc_dist.sv @@
// Distance pipeline and running minimum of the classifier.
// Depends on nnc_pkg; fed by the table read port of nnc_store.
module nnc_dist import nnc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIST_W-1:0]  limit_i,
  input  feat_vec_t          query_i,
  input  nnc_tag_t           tag_i,
  input  logic [LABEL_W-1:0] rd_label_i,
  input  feat_vec_t          rd_feat_i,
  output logic               done_o,
  output logic [LABEL_W-1:0] best_label_o,
  output logic [DIST_W-1:0]  best_dist_o,
  output logic               found_o
);

  nnc_tag_t tag0_q, tag1_q, tag2_q, tag3_q;
  logic [LABEL_W-1:0] label1_q, label2_q, label3_q;
  logic [NUM_FEAT-1:0][FEAT_W-1:0] diff_q;
  logic [NUM_FEAT-1:0][SQ_W-1:0]   sq_q;
  logic [DIST_W-1:0] sum_q;
  logic [DIST_W-1:0] best_q;
  logic [LABEL_W-1:0] best_label_q;
  logic found_q, done_q;
  logic take;

  // Tags follow the data; the first tag lines up with the table read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag0_q <= tag_i;
      tag1_q <= tag0_q;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // Stage 1: feature differences.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_FEAT; k++) begin
      diff_q[k] <= abs_diff(rd_feat_i[k], query_i[k]);
    end
    label1_q <= rd_label_i;
  end

  // Stage 2: one square per feature.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_FEAT; k++) begin
      sq_q[k] <= SQ_W'(diff_q[k]) * SQ_W'(diff_q[k]);
    end
    label2_q <= label1_q;
  end

  // Stage 3: sum of the squares.
  always_ff @(posedge clk_i) begin
    sum_q    <= DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]) + DIST_W'(sq_q[3]);
    label3_q <= label2_q;
  end

  // Stage 4: strict compare against the running minimum.
  assign take = tag3_q.active && tag3_q.entry && (sum_q < best_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      best_q       <= limit_i;
      best_label_q <= '0;
    end else if (take) begin
      best_q       <= sum_q;
      best_label_q <= label3_q;
    end
  end

  // The result stays valid until the next query starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (take) begin
        found_q <= 1'b1;
      end
      if (tag3_q.active && tag3_q.last) begin
        done_q <= 1'b1;
      end
    end
  end

  assign done_o       = done_q;
  assign best_label_o = best_label_q;
  assign best_dist_o  = best_q;
  assign found_o      = found_q;

endmodule

@@ hdl/nearest_neighbour_classifier.sv @@
// Nearest-neighbour classifier: query sequencer, registers and output stage.
// A load does not close the input. A query scans n = min(sample_count, TABLE_DEPTH)
// entries, one table read per cycle, into a four-stage distance pipeline;
// the input stays closed until its result is loaded into the output register,
// which waits while an earlier result is stalled. The table read port sets the pace.
// Reset clears control and sets configuration to its reset values; the table is undefined until loaded.
module nearest_neighbour_classifier import nnc_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream. tdata: entry_index, sample_label, feature_a, feature_b,
  // feature_c, feature_d (from bit 0 up). tuser: command.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  // Output stream. tdata: nearest_label, nearest_distance, match_found
  // (from bit 0 up).
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [DIST_W-1:0]      cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW:0] idx_inc;
  feat_vec_t query_q;
  logic [COUNT_W-1:0] sample_count_q;
  logic [DIST_W-1:0] distance_limit_q;
  logic out_valid_q, out_valid_d;
  logic [LABEL_W-1:0] out_label_q;
  logic [DIST_W-1:0] out_dist_q;
  logic out_found_q;

  logic in_xfer, load_xfer, query_xfer, out_free, last_slot, out_load;
  logic [INDEX_W-1:0] in_index;
  logic [LABEL_W-1:0] in_label;
  feat_vec_t in_feat;
  nnc_tag_t tag;
  logic [LABEL_W-1:0] rd_label, best_label;
  feat_vec_t rd_feat;
  logic [DIST_W-1:0] best_dist;
  logic done, found;

  // Input unpacking and transfer decode.
  assign in_index   = s_axis_tdata[IN_LABEL_LSB-1:IN_INDEX_LSB];
  assign in_label   = s_axis_tdata[IN_FEAT_LSB-1:IN_LABEL_LSB];
  assign in_feat    = s_axis_tdata[IN_USED_W-1:IN_FEAT_LSB];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign load_xfer  = in_xfer && (s_axis_tuser == CMD_LOAD) &&
                      (32'(in_index) < 32'(TABLE_DEPTH));
  assign query_xfer = in_xfer && (s_axis_tuser == CMD_QUERY);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q   <= RESET_SAMPLE_COUNT;
      distance_limit_q <= RESET_DISTANCE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SAMPLE_COUNT:   sample_count_q   <= cfg_data_i[COUNT_W-1:0];
        CFG_DISTANCE_LIMIT: distance_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scan sequencer.
  assign idx_inc   = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
  assign last_slot = (n_q == '0) || (idx_inc >= {1'b0, n_q});
  assign out_free  = !out_valid_q || m_axis_tready;
  assign out_load  = (state_q == ST_DRAIN) && done && out_free;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    n_d     = n_q;
    tag     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (query_xfer) begin
          idx_d   = '0;
          n_d     = (32'(sample_count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(sample_count_q);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        tag.active = 1'b1;
        tag.entry  = (n_q != '0);
        tag.last   = last_slot;
        idx_d      = idx_inc[CW-1:0];
        if (last_slot) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
    end
  end

  // Query features are held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      query_q <= in_feat;
    end
  end

  // Sample table.
  nnc_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (load_xfer),
    .wr_addr_i  (AW'(in_index)),
    .wr_label_i (in_label),
    .wr_feat_i  (in_feat),
    .rd_en_i    (tag.entry),
    .rd_addr_i  (idx_q[AW-1:0]),
    .rd_label_o (rd_label),
    .rd_feat_o  (rd_feat)
  );

  // Distance pipeline and running minimum.
  nnc_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (query_xfer),
    .limit_i      (distance_limit_q),
    .query_i      (query_q),
    .tag_i        (tag),
    .rd_label_i   (rd_label),
    .rd_feat_i    (rd_feat),
    .done_o       (done),
    .best_label_o (best_label),
    .best_dist_o  (best_dist),
    .found_o      (found)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_label_q <= best_label;
      out_dist_q  <= best_dist;
      out_found_q <= found;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                          out_found_q, out_dist_q, out_label_q};

endmodule

@@ hdl/nnc_checker.sv @@
// Port-level checks of the nearest-neighbour classifier, bound to the top level.
// Depends on nnc_pkg and nearest_neighbour_classifier_macros.svh.
`include "nearest_neighbour_classifier_macros.svh"

module nnc_checker import nnc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic query_xfer, load_xfer;
  logic out_found;
  logic [LABEL_W-1:0] out_label;

  assign query_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY);
  assign load_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD);
  assign out_found  = m_axis_tdata[OUT_FOUND_LSB];
  assign out_label  = m_axis_tdata[OUT_LABEL_LSB +: LABEL_W];

  // A query occupies the block, so the input closes right after its transfer.
  `NNC_ASSERT_NEXT(a_query_busy, query_xfer, !s_axis_tready, "input open after query")

  // A load leaves the input open.
  `NNC_ASSERT_NEXT(a_load_single, load_xfer, s_axis_tready, "input closed after load")

  // A result without a match carries label zero.
  `NNC_ASSERT(a_nomatch_label, (m_axis_tvalid && !out_found) |-> (out_label == '0), "label set")

  // A stalled result holds.
  `NNC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind nearest_neighbour_classifier nnc_checker u_nnc_checker (.*);
